[hdl/cmor_pkg.sv]
package cmor_pkg;

  localparam int NOSC = 5;
  localparam logic [32:0] BASE_HZ_Q16 = 33'd17145922;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_BASE_PITCH    = 3'd0;
  localparam logic [2:0] REG_SHAPE_KNOB    = 3'd1;
  localparam logic [2:0] REG_SAMPLE_PERIOD = 3'd2;
  localparam logic [2:0] REG_OSC_TUNE_0    = 3'd3;

  localparam logic [22:0] SAMPLE_PERIOD_RESET = 23'd89478;

  typedef enum logic [28:0] {
    ST_IDLE    = 29'd1 << 0,
    ST_EXP_MUL = 29'd1 << 1,
    ST_EXP_ACC = 29'd1 << 2,
    ST_P_MUL   = 29'd1 << 3,
    ST_P_SUM   = 29'd1 << 4,
    ST_HZ_MUL  = 29'd1 << 5,
    ST_HZ_RND  = 29'd1 << 6,
    ST_T_MUL   = 29'd1 << 7,
    ST_P_UPD   = 29'd1 << 8,
    ST_W_FOLD  = 29'd1 << 9,
    ST_W_SQ    = 29'd1 << 10,
    ST_W_X2    = 29'd1 << 11,
    ST_W_C3M   = 29'd1 << 12,
    ST_W_C3    = 29'd1 << 13,
    ST_W_C2M   = 29'd1 << 14,
    ST_W_C2    = 29'd1 << 15,
    ST_W_C1M   = 29'd1 << 16,
    ST_W_C1    = 29'd1 << 17,
    ST_W_SM    = 29'd1 << 18,
    ST_W_S     = 29'd1 << 19,
    ST_L_MUL   = 29'd1 << 20,
    ST_L_ACC   = 29'd1 << 21,
    ST_E_MUL   = 29'd1 << 22,
    ST_E_CHK   = 29'd1 << 23,
    ST_R_SET   = 29'd1 << 24,
    ST_A_MUL   = 29'd1 << 25,
    ST_A_FIN   = 29'd1 << 26,
    ST_DONE    = 29'd1 << 27,
    ST_SPARE   = 29'd1 << 28
  } state_t;

  // Q16 values of 2^(2^-k), k = 1..11, for one bit of an 11-bit fraction.
  function automatic logic [32:0] exp_coef(input logic [3:0] k);
    logic [32:0] c;
    unique case (k)
      4'd0:    c = 33'd92682;
      4'd1:    c = 33'd77936;
      4'd2:    c = 33'd71468;
      4'd3:    c = 33'd68438;
      4'd4:    c = 33'd66971;
      4'd5:    c = 33'd66250;
      4'd6:    c = 33'd65892;
      4'd7:    c = 33'd65714;
      4'd8:    c = 33'd65625;
      4'd9:    c = 33'd65580;
      4'd10:   c = 33'd65558;
      default: c = 33'd65536;
    endcase
    return c;
  endfunction

endpackage

[hdl/cross_modulated_oscillator_ring.sv]
// Each accepted beat is worked through step by step on one shared
// 33x33 multiplier that serves the exponent, pitch, sine, log and shape steps in turn.
// The input stalls until the result is loaded, so a beat is finished before the next is taken.
// A finished result waits in the output register while the next beat is taken.
// Reset (synchronous, active high) zeroes all phases and previous outputs and restores
// register defaults.
module cross_modulated_oscillator_ring import cmor_pkg::*; #(
  parameter int PHASE_BITS = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] base_pitch_cv,
  input  logic signed [15:0] shape_cv,
  input  logic signed [15:0] mod_cv_0,
  input  logic signed [15:0] mod_cv_1,
  input  logic signed [15:0] mod_cv_2,
  input  logic signed [15:0] mod_cv_3,
  input  logic signed [15:0] mod_cv_4,
  input  logic        [4:0]  mod_connected,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [14:0] wave_out_0,
  output logic signed [14:0] wave_out_1,
  output logic signed [14:0] wave_out_2,
  output logic signed [14:0] wave_out_3,
  output logic signed [14:0] wave_out_4,
  input  logic               cfg_we,
  input  logic        [2:0]  cfg_index,
  input  logic        [31:0] cfg_data
);

  state_t state, exp_ret;

  logic signed [13:0] base_pitch;
  logic        [13:0] shape_knob;
  logic        [22:0] sample_period;
  logic        [31:0] osc_tune [NOSC];

  logic [PHASE_BITS-1:0] osc_phase [NOSC];
  logic [15:0]           last_wave [NOSC];

  logic signed [15:0] cv_r;
  logic signed [15:0] mod_r [NOSC];
  logic        [4:0]  conn_r;
  logic        [6:0]  uw_hi;
  logic        [16:0] mq;
  logic        [2:0]  j;

  logic [10:0] exp_f;
  logic [3:0]  exp_k;
  logic [16:0] exp_m;

  logic [10:0] e_raw;
  logic [25:0] hz;
  logic [16:0] xv, x2, tc, mant, rv;
  logic [1:0]  quad;
  logic [4:0]  lg_int, ish;
  logic [15:0] frac;
  logic [3:0]  it;

  logic signed [32:0] ma, mb;
  logic signed [65:0] prod;

  // Combinational helpers.
  logic signed [19:0] uw20;
  logic [2:0]         prev_j;
  logic signed [15:0] mval;
  logic signed [18:0] sum19;
  logic signed [33:0] p22;
  logic [33:0]        u34;
  logic [47:0]        hz_tmp;
  logic [33:0]        exp_tmp;
  logic [48:0]        tval;
  logic signed [12:0] sh;
  logic signed [12:0] nsh;
  logic [63:0]        shv;
  logic [PHASE_BITS-1:0] inc;
  logic [17:0]        p18;
  logic [17:0]        s18;
  logic [16:0]        av;
  logic [4:0]         lead;
  logic [17:0]        sq;
  logic [20:0]        nl;
  logic [37:0]        ev;
  logic [6:0]         rsh;
  logic [15:0]        eq11;
  logic [31:0]        amp_tmp;
  logic [15:0]        val;

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    uw20   = 20'sd131072 - (20'(shape_cv) + $signed({6'b0, shape_knob}));
    prev_j = (j == 3'd0) ? 3'(NOSC - 1) : j - 3'd1;
    mval   = conn_r[j] ? mod_r[j] : $signed(last_wave[prev_j]);
    sum19  = 19'(cv_r) + 19'(base_pitch) + 19'($signed(osc_tune[j][31:16]));
    p22    = (34'(sum19) <<< 11) + 34'($signed(prod[31:0]));
    u34    = 34'(p22 + 34'sd4294967296);
    hz_tmp = prod[47:0] + 48'd32768;
    exp_tmp = prod[33:0] + 34'd32768;

    // Phase increment: scale the Q16 product by 2^(e + PHASE_BITS - 48) and saturate.
    tval = prod[48:0];
    sh   = $signed({2'b0, e_raw}) - 13'sd1072 + 13'(PHASE_BITS);
    nsh  = -sh;
    shv  = '0;
    if (sh >= 13'sd0) begin
      shv = {15'b0, tval} << sh[3:0];
    end else if (nsh < 13'sd64) begin
      shv = {15'b0, tval} >> nsh[5:0];
    end
    if (tval == '0) begin
      inc = '0;
    end else if (sh > 13'sd14 || shv[63:PHASE_BITS] != '0) begin
      inc = '1;
    end else begin
      inc = shv[PHASE_BITS-1:0];
    end

    p18 = 18'({osc_phase[j], 18'b0} >> PHASE_BITS);

    s18 = prod[33:16];
    av  = (s18 > 18'd65536) ? 17'd65536 : s18[16:0];
    lead = 5'd0;
    for (int i = 0; i < 17; i++) begin
      if (av[i]) lead = 5'(i);
    end

    sq  = prod[33:16];
    nl  = {lg_int, 16'b0} - {5'b0, frac};
    rsh = 7'd80 - uw_hi;
    ev  = prod[37:0] >> rsh;
    eq11 = ev[20:5];
    amp_tmp = prod[31:0] + 32'd32768;
    val = amp_tmp[31:16];
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state)
      ST_EXP_MUL: begin
        ma = {16'b0, exp_m};
        mb = exp_f[4'd10 - exp_k] ? exp_coef(exp_k) : 33'd65536;
      end
      ST_P_MUL: begin
        ma = 33'($signed(osc_tune[j][15:0]));
        mb = 33'(mval);
      end
      ST_HZ_MUL: begin
        ma = BASE_HZ_Q16;
        mb = {16'b0, exp_m};
      end
      ST_T_MUL: begin
        ma = {7'b0, hz};
        mb = {10'b0, sample_period};
      end
      ST_W_SQ: begin
        ma = {16'b0, xv};
        mb = {16'b0, xv};
      end
      ST_W_C3M: begin
        ma = {16'b0, x2};
        mb = 33'd307;
      end
      ST_W_C2M, ST_W_C1M: begin
        ma = {16'b0, x2};
        mb = {16'b0, tc};
      end
      ST_W_SM: begin
        ma = {16'b0, xv};
        mb = {16'b0, tc};
      end
      ST_L_MUL: begin
        ma = {16'b0, mant};
        mb = {16'b0, mant};
      end
      ST_E_MUL: begin
        ma = {12'b0, nl};
        mb = {16'b0, mq};
      end
      ST_A_MUL: begin
        ma = {16'b0, rv};
        mb = 33'd10240;
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= ma * mb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      exp_ret       <= ST_IDLE;
      base_pitch    <= '0;
      shape_knob    <= '0;
      sample_period <= SAMPLE_PERIOD_RESET;
      out_valid     <= 1'b0;
      j             <= '0;
      for (int i = 0; i < NOSC; i++) begin
        osc_tune[i]  <= '0;
        osc_phase[i] <= '0;
        last_wave[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_BASE_PITCH:    base_pitch    <= $signed(cfg_data[13:0]);
          REG_SHAPE_KNOB:    shape_knob    <= cfg_data[13:0];
          REG_SAMPLE_PERIOD: sample_period <= cfg_data[22:0];
          default:           osc_tune[cfg_index - REG_OSC_TUNE_0] <= cfg_data;
        endcase
      end

      // In ST_DONE the valid flag is either reloaded or held by the stalled result.
      if (out_valid && !out_stall && state != ST_DONE) out_valid <= 1'b0;

      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            cv_r     <= base_pitch_cv;
            mod_r[0] <= mod_cv_0;
            mod_r[1] <= mod_cv_1;
            mod_r[2] <= mod_cv_2;
            mod_r[3] <= mod_cv_3;
            mod_r[4] <= mod_cv_4;
            conn_r   <= mod_connected;
            uw_hi    <= uw20[17:11];
            exp_f    <= uw20[10:0];
            exp_k    <= '0;
            exp_m    <= 17'd65536;
            exp_ret  <= ST_P_MUL;
            j        <= '0;
            state    <= ST_EXP_MUL;
          end
        end
        ST_EXP_MUL: state <= ST_EXP_ACC;
        ST_EXP_ACC: begin
          exp_m <= exp_tmp[32:16];
          if (exp_k == 4'd10) begin
            // The shape exponent is computed only once, ahead of the pitch loop, and kept for every oscillator.
            if (exp_ret == ST_P_MUL) mq <= exp_tmp[32:16];
            state <= exp_ret;
          end else begin
            exp_k <= exp_k + 4'd1;
            state <= ST_EXP_MUL;
          end
        end
        ST_P_MUL: state <= ST_P_SUM;
        ST_P_SUM: begin
          e_raw   <= u34[32:22];
          exp_f   <= u34[21:11];
          exp_k   <= '0;
          exp_m   <= 17'd65536;
          exp_ret <= ST_HZ_MUL;
          state   <= ST_EXP_MUL;
        end
        ST_HZ_MUL: state <= ST_HZ_RND;
        ST_HZ_RND: begin
          hz    <= hz_tmp[41:16];
          state <= ST_T_MUL;
        end
        ST_T_MUL: state <= ST_P_UPD;
        ST_P_UPD: begin
          osc_phase[j] <= osc_phase[j] + inc;
          if (j == 3'(NOSC - 1)) begin
            j     <= '0;
            state <= ST_W_FOLD;
          end else begin
            j     <= j + 3'd1;
            state <= ST_P_MUL;
          end
        end
        ST_W_FOLD: begin
          quad  <= p18[17:16];
          xv    <= p18[16] ? 17'd65536 - {1'b0, p18[15:0]} : {1'b0, p18[15:0]};
          state <= ST_W_SQ;
        end
        ST_W_SQ: state <= ST_W_X2;
        ST_W_X2: begin
          x2    <= prod[32:16];
          state <= ST_W_C3M;
        end
        ST_W_C3M: state <= ST_W_C3;
        ST_W_C3: begin
          tc    <= 17'd5223 - prod[32:16];
          state <= ST_W_C2M;
        end
        ST_W_C2M: state <= ST_W_C2;
        ST_W_C2: begin
          tc    <= 17'd42334 - prod[32:16];
          state <= ST_W_C1M;
        end
        ST_W_C1M: state <= ST_W_C1;
        ST_W_C1: begin
          tc    <= 17'd102944 - prod[32:16];
          state <= ST_W_SM;
        end
        ST_W_SM: state <= ST_W_S;
        ST_W_S: begin
          if (av == '0) begin
            last_wave[j] <= '0;
            if (j == 3'(NOSC - 1)) begin
              j     <= '0;
              state <= ST_DONE;
            end else begin
              j     <= j + 3'd1;
              state <= ST_W_FOLD;
            end
          end else begin
            mant   <= 17'(av << (5'd16 - lead));
            lg_int <= 5'd16 - lead;
            frac   <= '0;
            it     <= '0;
            state  <= ST_L_MUL;
          end
        end
        ST_L_MUL: state <= ST_L_ACC;
        ST_L_ACC: begin
          // One fraction bit of the log per squaring.
          if (sq[17]) begin
            mant <= sq[17:1];
            frac <= {frac[14:0], 1'b1};
          end else begin
            mant <= sq[16:0];
            frac <= {frac[14:0], 1'b0};
          end
          if (it == 4'd15) begin
            state <= ST_E_MUL;
          end else begin
            it    <= it + 4'd1;
            state <= ST_L_MUL;
          end
        end
        ST_E_MUL: state <= ST_E_CHK;
        ST_E_CHK: begin
          if (ev >= 38'd1114112) begin
            last_wave[j] <= '0;
            if (j == 3'(NOSC - 1)) begin
              j     <= '0;
              state <= ST_DONE;
            end else begin
              j     <= j + 3'd1;
              state <= ST_W_FOLD;
            end
          end else begin
            ish <= eq11[15:11];
            if (eq11[10:0] == '0) begin
              rv    <= 17'(17'd65536 >> eq11[15:11]);
              state <= ST_A_MUL;
            end else begin
              exp_f   <= 11'(12'd2048 - {1'b0, eq11[10:0]});
              exp_k   <= '0;
              exp_m   <= 17'd65536;
              exp_ret <= ST_R_SET;
              state   <= ST_EXP_MUL;
            end
          end
        end
        ST_R_SET: begin
          rv    <= exp_m >> ({1'b0, ish} + 6'd1);
          state <= ST_A_MUL;
        end
        ST_A_MUL: state <= ST_A_FIN;
        ST_A_FIN: begin
          last_wave[j] <= quad[1] ? -val : val;
          if (j == 3'(NOSC - 1)) begin
            j     <= '0;
            state <= ST_DONE;
          end else begin
            j     <= j + 3'd1;
            state <= ST_W_FOLD;
          end
        end
        ST_DONE: begin
          if (!out_valid || !out_stall) begin
            wave_out_0 <= $signed(last_wave[0][14:0]);
            wave_out_1 <= $signed(last_wave[1][14:0]);
            wave_out_2 <= $signed(last_wave[2][14:0]);
            wave_out_3 <= $signed(last_wave[3][14:0]);
            wave_out_4 <= $signed(last_wave[4][14:0]);
            out_valid  <= 1'b1;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[hdl/cmor_checker.sv]
module cmor_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [14:0] wave_out_0
);

  // An accepted beat keeps the block busy on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after accepted beat");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(wave_out_0))
    else $error("stalled result changed");

  a_out_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> wave_out_0 <= 15'sd10240 && wave_out_0 >= -15'sd10240)
    else $error("output beyond five volts");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind cross_modulated_oscillator_ring cmor_checker u_cmor_checker (.*);
